### design/rtp_pkg.sv
package rtp_pkg;

  localparam int WINDOW_DEF = 10;
  localparam int RANGE_W = 8;
  localparam int SPAN_W = 12;
  localparam int RSSI_W = 8;
  localparam int CFG_IDX_W = 1;
  localparam logic [SPAN_W-1:0] SPAN_RESET = 12'd600;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_Y = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SETUP,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

### design/rssi_trilateration_position_core.sv
// Position core: each beat carries three signed beacon readings whose magnitudes
// are filtered by a WINDOW-deep moving sum per beacon, trilaterated against a
// spacing equal to the running maximum range (as it stood before the beat) and
// scaled to screen pixels. The block takes one beat at a time. One shared squarer
// forms the three window-sum squares and (W*d)^2 one after another, then for each
// axis in turn a shift-and-add multiplier and a restoring divider work one bit a
// cycle. The result is held until it is read, and no input beat is taken while it
// waits; the next beat can be accepted in the cycle after the result is read.
module rssi_trilateration_position_core #(
  parameter int WINDOW = rtp_pkg::WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [rtp_pkg::RSSI_W-1:0] rssi_a,
  input  logic signed [rtp_pkg::RSSI_W-1:0] rssi_b,
  input  logic signed [rtp_pkg::RSSI_W-1:0] rssi_c,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rtp_pkg::SPAN_W-1:0]        pos_x,
  output logic [rtp_pkg::SPAN_W-1:0]        pos_y,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rtp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtp_pkg::SPAN_W-1:0]        cfg_data
);

  localparam int RW = rtp_pkg::RANGE_W;
  localparam int SW = rtp_pkg::SPAN_W;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int SUM_W = RW + $clog2(WINDOW + 1);
  // Denominator 2*W^2*d^2 width, numerators fit in the same plus one.
  localparam int DW = 2 * SUM_W + 2;
  localparam int NW = DW + SW;
  localparam int CNT_W = $clog2(NW + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  logic [SW-1:0] span_x, span_y;
  logic [RW-1:0] ring_a [WINDOW];
  logic [RW-1:0] ring_b [WINDOW];
  logic [RW-1:0] ring_c [WINDOW];
  logic [SUM_W-1:0] sum_a, sum_b, sum_c;
  logic [SLOT_W-1:0] ring_slot;
  logic [RW-1:0] spacing_max;

  rtp_pkg::state_t state, state_next;
  logic [RW-1:0] ra, rb, rc, m1, m2;
  logic [SUM_W-1:0] na, nb, nc;
  logic [SUM_W:0] wd;
  logic signed [DW+1:0] nx, ny;
  logic [DW-1:0] den;
  logic axis;
  logic [NW-1:0] acc, mcand, rem;
  logic [SW-1:0] mplier, quo;
  logic [CNT_W-1:0] cnt;
  logic [SW-1:0] res_x;
  logic [2*SUM_W+1:0] sqa, sqb, sqc, w2d2;
  logic [1:0] mul_sel;
  logic [SUM_W:0] sq_op;
  logic [2*SUM_W+1:0] sq;

  function automatic logic [RW-1:0] mag(input logic signed [RW-1:0] v);
    mag = v[RW-1] ? RW'(-v) : RW'(v);
  endfunction

  assign ra = mag(rssi_a);
  assign rb = mag(rssi_b);
  assign rc = mag(rssi_c);
  assign m1 = (ra > spacing_max) ? ra : spacing_max;
  assign m2 = (rb > m1) ? rb : m1;
  assign na = sum_a - SUM_W'(ring_a[ring_slot]) + SUM_W'(ra);
  assign nb = sum_b - SUM_W'(ring_b[ring_slot]) + SUM_W'(rb);
  assign nc = sum_c - SUM_W'(ring_c[ring_slot]) + SUM_W'(rc);

  always_comb begin
    case (mul_sel)
      2'd0:    sq_op = {1'b0, sum_a};
      2'd1:    sq_op = {1'b0, sum_b};
      2'd2:    sq_op = {1'b0, sum_c};
      default: sq_op = wd;
    endcase
  end

  assign sq = (2*SUM_W+2)'(sq_op) * (2*SUM_W+2)'(sq_op);
  assign nx = $signed({2'b0, sqa}) - $signed({2'b0, sqb}) + $signed({2'b0, w2d2});
  assign ny = $signed({2'b0, sqb}) - $signed({2'b0, sqc}) + $signed({2'b0, w2d2});

  assign in_ready = (state == rtp_pkg::ST_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rtp_pkg::ST_IDLE:  if (in_valid && in_ready) state_next = rtp_pkg::ST_MUL;
      rtp_pkg::ST_MUL:   if (mul_sel == 2'd3) state_next = rtp_pkg::ST_SETUP;
      rtp_pkg::ST_SETUP: state_next = rtp_pkg::ST_DIV;
      rtp_pkg::ST_DIV:   if (cnt == '0) state_next = rtp_pkg::ST_OUT;
      rtp_pkg::ST_OUT:   state_next = axis ? rtp_pkg::ST_IDLE : rtp_pkg::ST_SETUP;
      default:           state_next = rtp_pkg::ST_IDLE;
    endcase
  end

  // The squarer takes one operand a cycle, and its products are registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      span_x <= rtp_pkg::SPAN_RESET;
      span_y <= rtp_pkg::SPAN_RESET;
      sum_a <= '0;
      sum_b <= '0;
      sum_c <= '0;
      ring_slot <= '0;
      spacing_max <= RW'(1);
      out_valid <= 1'b0;
      axis <= 1'b0;
      mul_sel <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        ring_a[i] <= '0;
        ring_b[i] <= '0;
        ring_c[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        if (cfg_index == rtp_pkg::REG_SPAN_X) span_x <= cfg_data;
        if (cfg_index == rtp_pkg::REG_SPAN_Y) span_y <= cfg_data;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        rtp_pkg::ST_IDLE: begin
          if (in_valid && in_ready) begin
            wd <= (SUM_W + 1)'(WINDOW) * (SUM_W + 1)'(spacing_max);
            spacing_max <= (rc > m2) ? rc : m2;
            sum_a <= na;
            sum_b <= nb;
            sum_c <= nc;
            ring_a[ring_slot] <= ra;
            ring_b[ring_slot] <= rb;
            ring_c[ring_slot] <= rc;
            ring_slot <= (ring_slot == LAST_SLOT) ? '0 : ring_slot + 1'b1;
            axis <= 1'b0;
            mul_sel <= '0;
          end
        end
        rtp_pkg::ST_MUL: begin
          if (mul_sel == 2'd0) sqa <= sq;
          if (mul_sel == 2'd1) sqb <= sq;
          if (mul_sel == 2'd2) sqc <= sq;
          if (mul_sel == 2'd3) w2d2 <= sq;
          mul_sel <= mul_sel + 2'd1;
        end
        rtp_pkg::ST_SETUP: begin
          if (!axis) begin
            den <= DW'({w2d2, 1'b0});
          end
          mcand <= NW'(axis ? ny[DW-1:0] : nx[DW-1:0]);
          mplier <= axis ? span_y : span_x;
          acc <= '0;
          cnt <= CNT_W'(SW + NW);
          quo <= '0;
        end
        rtp_pkg::ST_DIV: begin
          // First SW steps multiply by shift and add, the rest divide bit-serially.
          if (cnt > CNT_W'(NW)) begin
            acc <= {acc[NW-2:0], 1'b0} + (mplier[SW-1] ? mcand : '0);
            mplier <= {mplier[SW-2:0], 1'b0};
            rem <= '0;
          end else if (cnt != '0) begin
            if ({rem[NW-2:0], acc[NW-1]} >= NW'(den)) begin
              rem <= {rem[NW-2:0], acc[NW-1]} - NW'(den);
              quo <= {quo[SW-2:0], 1'b1};
            end else begin
              rem <= {rem[NW-2:0], acc[NW-1]};
              quo <= {quo[SW-2:0], 1'b0};
            end
            acc <= {acc[NW-2:0], 1'b0};
          end
          if (cnt != '0) cnt <= cnt - 1'b1;
        end
        rtp_pkg::ST_OUT: begin
          if (!axis) begin
            if (nx <= 0) res_x <= '0;
            else if (nx >= $signed({2'b0, den})) res_x <= span_x;
            else res_x <= quo;
            axis <= 1'b1;
          end else begin
            pos_x <= res_x;
            if (ny <= 0) pos_y <= '0;
            else if (ny >= $signed({2'b0, den})) pos_y <= span_y;
            else pos_y <= quo;
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
